/* hw/rtl/pli_pkg.sv */
package pli_pkg;

    localparam int DW    = 16;  // x and y width
    localparam int CNT_W = 5;   // pair_count register width
    localparam int IDX_W = 4;   // entry_index width

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd            command;
        logic [IDX_W-1:0] entry_index;
        logic [DW-1:0]   entry_x;
        logic [DW-1:0]   entry_y;
        logic [DW-1:0]   query_x;
    } t_req;

    typedef struct packed {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
    } t_entry;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] y;
    } t_res;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dy;
        logic [DW-1:0] off;
        logic [DW-1:0] span;
    } t_md_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
    } t_md_rsp;

endpackage

/* hw/rtl/pli_ram.sv */
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pli_muldiv.sv */
module pli_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pli_pkg::t_md_req i_req,
    output pli_pkg::t_md_rsp o_rsp
);
    import pli_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} t_state;

    t_state          r_state;
    logic [3:0]      r_cnt;
    logic [2*DW-1:0] r_acc;
    logic [DW-1:0]   r_mplr;
    logic [DW-1:0]   r_mcand;
    logic [DW-1:0]   r_span;
    logic            r_done;

    logic [2*DW-1:0] n_acc_mul;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            take;

    // multiply: MSB first shift-add, one multiplier bit per cycle
    assign n_acc_mul = {r_acc[2*DW-2:0], 1'b0} + (r_mplr[DW-1] ? {{DW{1'b0}}, r_mcand} : '0);

    // divide: upper half is the partial remainder, lower half shifts dividend out
    // and quotient in; quotient fits DW bits since the product is below span << DW
    assign trial = r_acc[2*DW-1:DW-1];
    assign diff  = trial - {1'b0, r_span};
    assign take  = (trial >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_acc   <= '0;
                        r_mplr  <= i_req.off;
                        r_mcand <= i_req.dy;
                        r_span  <= i_req.span;
                        r_cnt   <= '0;
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_acc  <= n_acc_mul;
                    r_mplr <= {r_mplr[DW-2:0], 1'b0};
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= M_DIV;
                    end
                end
                M_DIV: begin
                    r_acc[2*DW-1:DW] <= take ? diff[DW-1:0] : trial[DW-1:0];
                    r_acc[DW-1:0]    <= {r_acc[DW-2:0], take};
                    r_cnt            <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc[DW-1:0];

`ifndef SYNTH
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_DIV) |-> (r_acc[2*DW-1:DW] < r_span))
        else $error("partial remainder not below span");
`endif

endmodule

/* hw/rtl/pli_seq.sv */
module pli_seq #(
    parameter int MAX_PAIRS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  pli_pkg::t_req              i_req,
    input  logic [pli_pkg::CNT_W-1:0]  i_pair_count,
    output pli_pkg::t_res              o_res,
    input  logic                       i_res_ready
);
    import pli_pkg::*;

    localparam int IW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_CHK0, S_CHKN, S_WALK, S_MD, S_FIN} t_state;

    t_state        r_state;
    logic [IW-1:0] r_last;
    logic [IW-1:0] r_i;
    logic [DW-1:0] r_query;
    t_entry        r_e0;
    t_entry        r_prev;
    logic          r_dir;
    logic [DW-1:0] r_base;
    logic          r_res_valid;
    logic [DW-1:0] r_res_y;
    logic          r_md_start;
    logic [DW-1:0] r_md_dy;
    logic [DW-1:0] r_md_off;
    logic [DW-1:0] r_md_span;

    logic          accept;
    logic          ram_we;
    logic [NW-1:0] pc_ext;
    logic [NW-1:0] eff;
    logic [IW-1:0] rd_addr;
    t_entry        rd_q;
    logic          in_seg;
    t_md_req       md_req;
    t_md_rsp       md_rsp;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign ram_we      = accept && (i_req.command == CMD_LOAD)
                         && (32'(i_req.entry_index) < MAX_PAIRS);

    assign pc_ext = NW'(i_pair_count);
    assign eff    = (pc_ext > NW'(MAX_PAIRS)) ? NW'(MAX_PAIRS) : pc_ext;

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = '0;
            S_CHK0:  rd_addr = r_last;
            S_CHKN:  rd_addr = IW'(1);
            S_WALK:  rd_addr = r_i + IW'(1);
            default: rd_addr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH (2 * DW),
        .DEPTH (MAX_PAIRS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(i_req.entry_index)),
        .i_wdata ({i_req.entry_x, i_req.entry_y}),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    assign md_req.start = r_md_start;
    assign md_req.dy    = r_md_dy;
    assign md_req.off   = r_md_off;
    assign md_req.span  = r_md_span;

    pli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // segment [prev, current read] holds the query
    assign in_seg = (r_query >= r_prev.x) && (r_query <= rd_q.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_md_start  <= 1'b0;
        end else begin
            r_md_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_req.command == CMD_LOOKUP)) begin
                        r_query <= i_req.query_x;
                        r_last  <= IW'(eff - NW'(1));
                        if (eff == '0) begin
                            r_res_y     <= '0;
                            r_res_valid <= 1'b1;
                            r_state     <= S_FIN;
                        end else begin
                            r_state <= S_CHK0;
                        end
                    end
                end
                S_CHK0: begin
                    r_e0 <= rd_q;
                    if (r_query <= rd_q.x) begin
                        r_res_y     <= rd_q.y;
                        r_res_valid <= 1'b1;
                        r_state     <= S_FIN;
                    end else begin
                        r_state <= S_CHKN;
                    end
                end
                S_CHKN: begin
                    if (r_query >= rd_q.x) begin
                        r_res_y     <= rd_q.y;
                        r_res_valid <= 1'b1;
                        r_state     <= S_FIN;
                    end else begin
                        r_prev  <= r_e0;
                        r_i     <= IW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (in_seg) begin
                        if (r_query == r_prev.x) begin
                            r_res_y     <= r_prev.y;
                            r_res_valid <= 1'b1;
                            r_state     <= S_FIN;
                        end else begin
                            r_dir      <= (rd_q.y > r_prev.y);
                            r_base     <= r_prev.y;
                            r_md_dy    <= (rd_q.y > r_prev.y) ? (rd_q.y - r_prev.y)
                                                               : (r_prev.y - rd_q.y);
                            r_md_off   <= r_query - r_prev.x;
                            r_md_span  <= rd_q.x - r_prev.x;
                            r_md_start <= 1'b1;
                            r_state    <= S_MD;
                        end
                    end else if (r_i == r_last) begin
                        // unsorted table: no segment matched
                        r_res_y     <= r_e0.y;
                        r_res_valid <= 1'b1;
                        r_state     <= S_FIN;
                    end else begin
                        r_prev <= rd_q;
                        r_i    <= r_i + IW'(1);
                    end
                end
                S_MD: begin
                    if (md_rsp.done) begin
                        r_res_y     <= r_dir ? (r_base + md_rsp.quot) : (r_base - md_rsp.quot);
                        r_res_valid <= 1'b1;
                        r_state     <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_res_ready) begin
                        r_res_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.y     = r_res_y;

`ifndef SYNTH
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.command == CMD_LOAD)) |=> (r_state == S_IDLE && !r_res_valid))
        else $error("load request produced a result");

    a_md_done_in_md: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_MD))
        else $error("divider finished outside interpolation");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_i <= r_last))
        else $error("segment walk past last active entry");
`endif

endmodule

/* hw/rtl/piecewise_linear_table_interpolator_top.sv */
// Piecewise-linear lookup table with up to MAX_PAIRS (x, y) breakpoints held in a
// single-port-write RAM. A load request (command 0) writes one entry in the cycle it is
// accepted and gives no result; loads at an index at or beyond MAX_PAIRS are dropped.
// A lookup request (command 1) gives one result_y: 0 with no active pairs, the end y
// when query_x is at or beyond either end, otherwise the first matching segment
// interpolated with truncation, or entry 0's y when no segment matches. Entries must be
// loaded before a lookup reads them. One request is in flight at a time. A lookup with
// no active pairs gives its result without reading the RAM; otherwise it checks entry 0,
// then the last active entry, and if it does not clamp it walks the segments (one RAM
// read per cycle), then starts the divider for the bit-serial multiply and the 16-step
// divide. The output register lets the next request start while a result waits.
// pair_count may be written only while idle.
module piecewise_linear_table_interpolator_top #(
    parameter int MAX_PAIRS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pli_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [pli_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [pli_pkg::DW-1:0]     i_entry_x,
    input  logic [pli_pkg::DW-1:0]     i_entry_y,
    input  logic [pli_pkg::DW-1:0]     i_query_x,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [pli_pkg::DW-1:0]     o_result_y
);
    import pli_pkg::*;

    logic [CNT_W-1:0] r_pair_count;
    logic             r_out_valid;
    logic [DW-1:0]    r_out_y;

    t_req             req;
    t_res             res;
    logic             res_ready;

    assign req.command     = t_cmd'(i_command);
    assign req.entry_index = i_entry_index;
    assign req.entry_x     = i_entry_x;
    assign req.entry_y     = i_entry_y;
    assign req.query_x     = i_query_x;

    assign res_ready = !r_out_valid || i_out_ready;

    pli_seq #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_in_valid),
        .o_req_ready  (o_in_ready),
        .i_req        (req),
        .i_pair_count (r_pair_count),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pair_count <= i_cfg_data;
            end
            if (res.valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out_y     <= res.y;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_y  = r_out_y;

endmodule
